@@ src/glcd_pkg.sv @@
// Package for the graphic LCD column controller.
// Bus command codes, instruction byte patterns, default geometry and the
// control/status structs shared by the top level and the per-half datapath.
package glcd_pkg;

    localparam int DEF_COLUMNS = 64;
    localparam int DEF_PAGES   = 8;
    localparam int DEF_HALVES  = 2;

    // bus access kind, carried in tuser
    localparam logic [1:0] CMD_INSTR  = 2'd0;
    localparam logic [1:0] CMD_DWRITE = 2'd1;
    localparam logic [1:0] CMD_STATUS = 2'd2;
    localparam logic [1:0] CMD_DREAD  = 2'd3;

    localparam logic [7:0] INS_DISP_ON   = 8'h3F;
    localparam logic [7:0] INS_DISP_OFF  = 8'h3E;
    localparam logic [7:0] INS_COL       = 8'h40;
    localparam logic [7:0] INS_COL_MASK  = 8'hC0;
    localparam logic [7:0] INS_PAGE      = 8'hB8;
    localparam logic [7:0] INS_PAGE_MASK = 8'hF8;
    localparam logic [7:0] INS_ARG_COL   = 8'h3F;
    localparam logic [7:0] INS_ARG_PAGE  = 8'h07;

    localparam logic [7:0] STATUS_OFF = 8'h20;

    typedef struct packed {
        logic clear;    // clearing pass is running
        logic instr;    // instruction write to this half
        logic dwrite;   // data write to this half
        logic dread;    // data read from this half
        logic load;     // latch takes the RAM read data
    } half_ctl_t;

    typedef struct packed {
        logic       disp_on;
        logic [7:0] latch;
    } half_stat_t;

endpackage

@@ src/graphic_lcd_column_controller.sv @@
// Graphic LCD column controller, bus side.
// Item channel s_*: one bus access per item. tuser is the access kind
// (instruction write, data write, status read, data read), tdata carries the
// half selects and the bus byte. Result channel m_*: one read byte per item,
// zero for writes.
// Writes and status reads can be taken back to back while results are taken; a
// data read holds off the next item, since the output latch is reloaded from the
// display RAM, whose read data is registered, in the cycle after the item is accepted.
// Latency: the result is valid in the cycle after acceptance and sits in an
// output register; a new item is taken in the same cycle that the pending
// result is taken.
// Reset: all half registers return to their reset values and a clearing pass
// zeroes all PAGES*COLUMNS display RAM entries (512 with the defaults), all
// halves in parallel; s_tready stays low during it.
// Stall: while m_tvalid is high and m_tready low, s_tready is held low.
module graphic_lcd_column_controller #(
    parameter int COLUMNS = glcd_pkg::DEF_COLUMNS,
    parameter int PAGES   = glcd_pkg::DEF_PAGES,
    parameter int HALVES  = glcd_pkg::DEF_HALVES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sel_left, sel_right, bus_byte[7:0], zero pad
    input  logic [1:0]  s_tuser,   // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // read_byte
);

    import glcd_pkg::*;

    localparam int AW = $clog2(PAGES*COLUMNS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOAD  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [HALVES-1:0] load_mask_reg, load_mask_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    logic              accept;
    logic              sel_left, sel_right;
    logic [7:0]        bus_byte;
    logic [HALVES-1:0] wr_sel;
    logic [HALVES-1:0] rd_sel;
    logic              rd_any;
    half_stat_t        stat [HALVES];
    half_stat_t        rd_stat;
    logic [7:0]        read_byte;

    assign sel_left  = s_tdata[0];
    assign sel_right = s_tdata[1];
    assign bus_byte  = s_tdata[9:2];

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    // with one half the right select falls off the top
    assign wr_sel = HALVES'({sel_right, sel_left});
    assign rd_sel = HALVES'({~sel_left & sel_right, sel_left});
    assign rd_any = |rd_sel;
    assign rd_stat = sel_left ? stat[0] : stat[HALVES-1];

    for (genvar h = 0; h < HALVES; h++)
    begin : g_half
        half_ctl_t ctl;

        assign ctl.clear  = (state_reg == ST_CLEAR);
        assign ctl.instr  = accept && (s_tuser == CMD_INSTR) && wr_sel[h];
        assign ctl.dwrite = accept && (s_tuser == CMD_DWRITE) && wr_sel[h];
        assign ctl.dread  = accept && (s_tuser == CMD_DREAD) && rd_sel[h];
        assign ctl.load   = (state_reg == ST_LOAD) && load_mask_reg[h];

        glcd_half #(
            .COLUMNS (COLUMNS),
            .PAGES   (PAGES)
        ) u_half (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .clr_addr (clr_cnt_reg),
            .bus_byte (bus_byte),
            .stat     (stat[h])
        );
    end

    always_comb
    begin
        read_byte = 8'h00;
        if (rd_any)
        begin
            if (s_tuser == CMD_STATUS)
            begin
                read_byte = rd_stat.disp_on ? 8'h00 : STATUS_OFF;
            end
            else if (s_tuser == CMD_DREAD)
            begin
                read_byte = rd_stat.latch;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        load_mask_next = load_mask_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(PAGES*COLUMNS-1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = read_byte;
                    if (s_tuser == CMD_DREAD)
                    begin
                        load_mask_next = rd_sel;
                        state_next     = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                load_mask_next = '0;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            load_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            load_mask_reg <= load_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ src/glcd_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module glcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/glcd_half.sv @@
// One display half: address, page, display flag and output latch registers
// around a display RAM. Uses glcd_pkg and glcd_ram.
module glcd_half #(
    parameter int COLUMNS = glcd_pkg::DEF_COLUMNS,
    parameter int PAGES   = glcd_pkg::DEF_PAGES
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  glcd_pkg::half_ctl_t                   ctl,
    input  logic [$clog2(PAGES*COLUMNS)-1:0]      clr_addr,
    input  logic [7:0]                            bus_byte,
    output glcd_pkg::half_stat_t                  stat
);

    import glcd_pkg::*;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW     = $clog2(PAGES*COLUMNS);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic              on_reg, on_next;
    logic              aas_reg, aas_next;
    logic [7:0]        latch_reg, latch_next;

    logic [COL_W:0]    col_sum;
    logic [COL_W-1:0]  col_inc;
    logic [COL_W-1:0]  acc_col;
    logic [5:0]        col_arg;
    logic [2:0]        page_arg;
    logic [AW-1:0]     acc_addr;
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // column + 1, wrapping at COLUMNS
    assign col_sum = (COL_W+1)'(col_reg) + (COL_W+1)'(1);
    assign col_inc = (col_sum >= (COL_W+1)'(COLUMNS)) ? '0 : col_sum[COL_W-1:0];

    // a read that does not follow an address command fetches the next column
    assign acc_col  = (ctl.dread && !aas_reg) ? col_inc : col_reg;
    assign acc_addr = AW'(AW'(page_reg) * AW'(COLUMNS) + AW'(acc_col));

    // instruction arguments reduced modulo the geometry by repeated subtraction
    always_comb
    begin
        col_arg  = bus_byte[5:0];
        page_arg = bus_byte[2:0];
        for (int i = 0; i < 8; i++)
        begin
            if ({1'b0, col_arg} >= 7'(COLUMNS))
            begin
                col_arg = col_arg - 6'(COLUMNS);
            end
            if ({1'b0, page_arg} >= 4'(PAGES))
            begin
                page_arg = page_arg - 3'(PAGES);
            end
        end
    end

    always_comb
    begin
        col_next   = col_reg;
        page_next  = page_reg;
        on_next    = on_reg;
        aas_next   = aas_reg;
        latch_next = latch_reg;
        if (ctl.instr)
        begin
            if (bus_byte == INS_DISP_ON)
            begin
                on_next = 1'b1;
            end
            else if (bus_byte == INS_DISP_OFF)
            begin
                on_next = 1'b0;
            end
            else if ((bus_byte & INS_COL_MASK) == INS_COL)
            begin
                col_next = COL_W'(col_arg);
                aas_next = 1'b1;
            end
            else if ((bus_byte & INS_PAGE_MASK) == INS_PAGE)
            begin
                page_next = PAGE_W'(page_arg);
                aas_next  = 1'b1;
            end
        end
        if (ctl.dwrite)
        begin
            col_next = col_inc;
        end
        if (ctl.dread)
        begin
            col_next = acc_col;
            aas_next = 1'b0;
        end
        if (ctl.load)
        begin
            latch_next = ram_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            page_reg  <= '0;
            on_reg    <= 1'b0;
            aas_reg   <= 1'b1;
            latch_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            page_reg  <= page_next;
            on_reg    <= on_next;
            aas_reg   <= aas_next;
            latch_reg <= latch_next;
        end
    end

    assign ram_we    = ctl.clear || ctl.dwrite;
    assign ram_addr  = ctl.clear ? clr_addr : acc_addr;
    assign ram_wdata = ctl.clear ? 8'h00 : bus_byte;

    glcd_ram #(
        .WIDTH (8),
        .DEPTH (PAGES*COLUMNS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign stat.disp_on = on_reg;
    assign stat.latch   = latch_reg;

endmodule

@@ src/glcd_checker.sv @@
// Port-level checks for the graphic LCD column controller, bound to the top.
// Uses glcd_pkg for the access kind codes.
module glcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    import glcd_pkg::*;

    logic in_acc;

    assign in_acc = s_tvalid && s_tready;

    // a stalled result blocks new items
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("item accepted while result stalled");

    // every item leaves a result behind in the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_tvalid)
        else $error("no result after accepted item");

    // writes return zero
    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (s_tuser == CMD_INSTR || s_tuser == CMD_DWRITE))
        |=> (m_tdata == 8'h00))
        else $error("write returned nonzero byte");

    // status only reports the display-off flag
    a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == CMD_STATUS)
        |=> (m_tdata == 8'h00 || m_tdata == STATUS_OFF))
        else $error("bad status byte");

    // a data read holds off the next item for the latch reload
    a_read_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_tuser == CMD_DREAD) |=> !s_tready)
        else $error("item accepted during latch reload");

endmodule

bind graphic_lcd_column_controller glcd_checker u_glcd_checker (.*);

@@ dv/graphic_lcd_column_controller_test.sv @@
// Testbench for the graphic LCD column controller (bus side).
// Predicts every read byte from a model of both halves and checks each result item.
// Depends on glcd_pkg and graphic_lcd_column_controller from src.
module graphic_lcd_column_controller_test;
    import glcd_pkg::*;

    localparam logic [7:0] INS_START_LINE = 8'hC0;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 375;
    localparam int HOLD_CYCLES    = 300;

    // expected read bytes, predicted from a copy of both halves
    class glcd_scoreboard;
        logic [7:0] ram [0:1023];
        logic [5:0] column [2];
        logic [2:0] page [2];
        logic [5:0] start_line [2];
        logic       disp_on [2];
        logic [7:0] latch [2];
        logic       addr_fresh [2];
        logic [7:0] expected_reads [$];
        int         mismatches;
        int         results_seen;

        function new();
            foreach (ram[i])
                ram[i] = '0;
            for (int h = 0; h < 2; h++)
            begin
                column[h]     = '0;
                page[h]       = '0;
                start_line[h] = '0;
                disp_on[h]    = 1'b0;
                latch[h]      = '0;
                addr_fresh[h] = 1'b1;
            end
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void note_access(logic [1:0] cmd, logic [1:0] sel, logic [7:0] b);
            logic [7:0] result;
            int         h;
            result = '0;
            if (cmd == CMD_INSTR || cmd == CMD_DWRITE)
            begin
                for (int i = 0; i < 2; i++)
                begin
                    if (!sel[i])
                        continue;
                    if (cmd == CMD_DWRITE)
                    begin
                        ram[{1'(i), page[i], column[i]}] = b;
                        column[i] = column[i] + 6'd1;
                    end
                    else if (b == INS_DISP_ON)
                        disp_on[i] = 1'b1;
                    else if (b == INS_DISP_OFF)
                        disp_on[i] = 1'b0;
                    else if ((b & INS_COL_MASK) == INS_COL)
                    begin
                        column[i]     = 6'(b & INS_ARG_COL);
                        addr_fresh[i] = 1'b1;
                    end
                    else if ((b & INS_PAGE_MASK) == INS_PAGE)
                    begin
                        page[i]       = 3'(b & INS_ARG_PAGE);
                        addr_fresh[i] = 1'b1;
                    end
                    else if ((b & INS_COL_MASK) == INS_START_LINE)
                        start_line[i] = 6'(b & INS_ARG_COL);
                end
            end
            else if (sel != 2'b00)
            begin
                // left half wins when both are selected
                h = sel[0] ? 0 : 1;
                if (cmd == CMD_STATUS)
                    result = disp_on[h] ? 8'h00 : STATUS_OFF;
                else
                begin
                    result = latch[h];
                    if (addr_fresh[h])
                        addr_fresh[h] = 1'b0;
                    else
                        column[h] = column[h] + 6'd1;
                    latch[h] = ram[{h[0], page[h], column[h]}];
                end
            end
            expected_reads.push_back(result);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $time, msg);
        endtask

        task check_read(logic [7:0] got);
            logic [7:0] want;
            results_seen++;
            if (expected_reads.size() == 0)
            begin
                report($sformatf("result 0x%02h with no access outstanding", got));
                return;
            end
            want = expected_reads.pop_front();
            if (got !== want)
                report($sformatf("read_byte 0x%02h, expected 0x%02h", got, want));
        endtask
    endclass

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = CMD_INSTR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    glcd_scoreboard sb;
    int  items_sent   = 0;
    int  cmd_count [4] = '{0, 0, 0, 0};
    bit  sender_idles = 1'b1;
    bit  ready_idles  = 1'b1;
    bit  hold_req     = 1'b0;

    graphic_lcd_column_controller uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("graphic_lcd_column_controller_test failed");
        $finish;
    end

    // offer one bus access and wait for it to be taken
    task automatic send(input logic [1:0] cmd, input logic [1:0] sel, input logic [7:0] b);
        while (sender_idles && $urandom_range(0, 99) < 26)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, b, sel};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_access(cmd, sel, b);
        cmd_count[cmd]++;
        items_sent++;
    endtask

    function automatic logic [1:0] pick_sel();
        case ($urandom_range(0, 9)) inside
            0:       return 2'b00;
            1, 2:    return 2'b11;
            3, 4, 5: return 2'b01;
            default: return 2'b10;
        endcase
    endfunction

    function automatic logic [7:0] random_instr();
        case ($urandom_range(0, 5))
            0:       return INS_DISP_ON;
            1:       return INS_DISP_OFF;
            2:       return INS_COL | 8'($urandom_range(0, 63));
            3:       return INS_PAGE | 8'($urandom_range(0, 7));
            4:       return INS_START_LINE | 8'($urandom_range(0, 63));
            default: return 8'($urandom);
        endcase
    endfunction

    // address a run of columns, write it, rewind, then read it back
    task automatic send_burst();
        logic [1:0] sel;
        logic [5:0] col;
        int         len;
        sel = pick_sel();
        len = $urandom_range(1, 8);
        col = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(56, 63)) : 6'($urandom);
        if ($urandom_range(0, 1) == 0)
            send(CMD_INSTR, sel, random_instr());
        send(CMD_INSTR, sel, INS_PAGE | 8'($urandom_range(0, 7)));
        send(CMD_INSTR, sel, INS_COL | 8'(col));
        repeat (len)
            send(CMD_DWRITE, sel, 8'($urandom));
        send(CMD_INSTR, sel, INS_COL | 8'(col));
        repeat (len + 1)
            send(CMD_DREAD, sel, 8'($urandom));
        if ($urandom_range(0, 2) == 0)
            send(CMD_STATUS, sel, 8'($urandom));
    endtask

    task automatic send_noise();
        logic [1:0] cmd;
        repeat ($urandom_range(1, 4))
        begin
            cmd = 2'($urandom);
            send(cmd, 2'($urandom), (cmd == CMD_INSTR) ? random_instr() : 8'($urandom));
        end
    endtask

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_read(m_tdata);

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            m_tready <= !(ready_idles && $urandom_range(0, 99) < 26);
        end
    end

    initial
    begin
        bit hold_done;
        bit drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        sb = new();
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // reset state, display on/off, page 7 with column wrap on both halves
        send(CMD_STATUS, 2'b01, 8'h00);
        send(CMD_STATUS, 2'b10, 8'hFF);
        send(CMD_DREAD,  2'b01, 8'h00);
        send(CMD_INSTR,  2'b11, INS_DISP_ON);
        send(CMD_STATUS, 2'b11, 8'h00);
        send(CMD_INSTR,  2'b10, INS_DISP_OFF);
        send(CMD_STATUS, 2'b10, 8'h00);
        send(CMD_INSTR,  2'b11, INS_PAGE | 8'd7);
        send(CMD_INSTR,  2'b11, INS_COL | 8'd63);
        send(CMD_DWRITE, 2'b11, 8'hFF);
        send(CMD_DWRITE, 2'b01, 8'h00);
        send(CMD_DWRITE, 2'b10, 8'hA5);
        send(CMD_INSTR,  2'b11, INS_COL | 8'd63);
        // dummy read, then a read that wraps the column
        send(CMD_DREAD,  2'b10, 8'h00);
        send(CMD_DREAD,  2'b10, 8'hFF);
        send(CMD_DREAD,  2'b10, 8'h00);
        send(CMD_DREAD,  2'b11, 8'h00);
        // nothing selected, then a start-line code on the left half
        send(CMD_INSTR,  2'b00, INS_DISP_ON);
        send(CMD_DWRITE, 2'b00, 8'h55);
        send(CMD_DREAD,  2'b00, 8'h00);
        send(CMD_STATUS, 2'b00, 8'h00);
        send(CMD_INSTR,  2'b01, INS_START_LINE | 8'd63);
        // codes that match no instruction, then display off on both halves
        send(CMD_INSTR,  2'b01, 8'h00);
        send(CMD_INSTR,  2'b10, 8'h80);
        send(CMD_INSTR,  2'b11, INS_DISP_OFF);

        while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            if (items_sent >= 120 && !hold_done)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (items_sent >= 300 && !drain_done)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.expected_reads.size() != 0)
                    @(posedge clk);
                drain_done = 1'b1;
            end
            sender_idles = !(items_sent >= 180 && items_sent < 260);
            ready_idles  = sender_idles;
            if ($urandom_range(0, 9) < 7)
                send_burst();
            else
                send_noise();
        end
        s_tvalid <= 1'b0;
        sender_idles = 1'b1;
        ready_idles  = 1'b1;

        while (sb.expected_reads.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
        if (sb.expected_reads.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_reads.size()));

        $display("covered %0d accesses: %0d instruction, %0d data write, %0d status, %0d read",
                 items_sent, cmd_count[CMD_INSTR], cmd_count[CMD_DWRITE],
                 cmd_count[CMD_STATUS], cmd_count[CMD_DREAD]);
        $display("%0d result items checked, %0d mismatches", sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("graphic_lcd_column_controller_test passed");
        else
            $display("graphic_lcd_column_controller_test failed");
        $finish;
    end
endmodule
